[rtl/core/circular_list_engine_macros.svh]
// Assertion macros shared by the circular list engine RTL.
// Depends on nothing; the asserting module must have clk and arst_n in scope.
`ifndef CIRCULAR_LIST_ENGINE_MACROS_SVH
`define CIRCULAR_LIST_ENGINE_MACROS_SVH
`ifndef ASSERT_OFF
`define CLE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define CLE_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define CLE_ASSERT(lbl, prop, msg)
`define CLE_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

[rtl/core/cle_pkg.sv]
// Package of the circular list engine: opcodes, status codes, controller states.
// Depends on nothing.
`default_nettype none
package cle_pkg;
	localparam int POOL_NODES_DEF = 32;

	localparam logic [2:0] OP_INS_FRONT  = 3'd0;
	localparam logic [2:0] OP_INS_BACK   = 3'd1;
	localparam logic [2:0] OP_INS_AFTER  = 3'd2;
	localparam logic [2:0] OP_INS_BEFORE = 3'd3;
	localparam logic [2:0] OP_DEL_FRONT  = 3'd4;
	localparam logic [2:0] OP_DEL_BACK   = 3'd5;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_EMPTY    = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [1:0] ST_FULL     = 2'd3;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_INS_RD,
		S_PRE,
		S_SRCH,
		S_INS_A,
		S_INS_B,
		S_DEL_RD,
		S_DEL_F,
		S_DEL_B,
		S_FIN
	} state_t;
endpackage
`default_nettype wire

[rtl/core/cle_node_mem.sv]
// Node pool storage: value and link memories with a shared registered read port.
// Depends on nothing; widths come from the top level parameters.
`default_nettype none
module cle_node_mem #(
	parameter int DEPTH = 32,
	parameter int IW = 5
) (
	input  wire logic                 clk,
	input  wire logic [IW-1:0]        rd_addr,
	output logic signed [31:0]        rd_val,
	output logic [IW-1:0]             rd_link,
	input  wire logic                 val_we,
	input  wire logic [IW-1:0]        val_addr,
	input  wire logic signed [31:0]   val_wdata,
	input  wire logic                 link_we,
	input  wire logic [IW-1:0]        link_addr,
	input  wire logic [IW-1:0]        link_wdata
);
	logic signed [31:0] val_mem [DEPTH];
	logic [IW-1:0] link_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (val_we) begin
			val_mem[val_addr] <= val_wdata;
		end
		rd_val <= val_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (link_we) begin
			link_mem[link_addr] <= link_wdata;
		end
		rd_link <= link_mem[rd_addr];
	end
endmodule
`default_nettype wire

[rtl/core/circular_list_engine.sv]
// Top level of the circular list engine: controller, free mask and output register.
// Depends on cle_pkg, cle_node_mem and circular_list_engine_macros.svh.
//
// Usage: the input channel (in_valid/in_ready) carries one operation per transfer:
// opcode, data_value and insert_value. The output channel (out_valid/out_ready)
// returns one result per operation: status, removed_value and list_length.
// The block works on one operation at a time. In the idle state it takes a transfer.
// Key searches and delete at the back walk the list one node per cycle through the
// node memory read port; the other operations do not walk the list.
// A finished result sits in an output register; the next operation is accepted
// while it waits, and that operation holds in its last step until the receiver
// takes the earlier result, so a stalled receiver stalls the block without loss.
// Reset marks every node free, empties the list and clears the output valid flag;
// the node memories need no clearing since only linked nodes are ever read.
`default_nettype none
`include "circular_list_engine_macros.svh"
module circular_list_engine #(
	parameter int POOL_NODES = cle_pkg::POOL_NODES_DEF,
	localparam int IW = $clog2(POOL_NODES),
	localparam int CW = $clog2(POOL_NODES + 1)
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [2:0]         opcode,
	input  wire logic signed [31:0] data_value,
	input  wire logic signed [31:0] insert_value,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [1:0]              status,
	output logic signed [31:0]      removed_value,
	output logic [CW-1:0]           list_length
);
	import cle_pkg::*;

	state_t state_q, state_c;

	// Operation being worked on.
	logic [2:0] op_q;
	logic signed [31:0] key_q, ins_q;

	// Walk and insert pointers: cur_q is the node a new one goes after,
	// nxt_q its successor, rd_q the node whose entry is being read.
	logic [IW-1:0] cur_q, nxt_q, rd_q, n_q, tnext_q;
	logic [CW-1:0] k_q;
	logic [1:0] status_q;
	logic signed [31:0] removed_q;

	// List state outside the node memories.
	logic [POOL_NODES-1:0] free_q;
	logic [IW-1:0] tail_q;
	logic [CW-1:0] count_q;

	logic out_valid_q;
	logic [1:0] out_status_q;
	logic signed [31:0] out_removed_q;
	logic [CW-1:0] out_length_q;

	// Memory port signals.
	logic [IW-1:0] rd_addr_c;
	logic signed [31:0] rd_val;
	logic [IW-1:0] rd_link;
	logic val_we_c, link_we_c;
	logic [IW-1:0] val_addr_c, link_addr_c, link_wdata_c;
	logic signed [31:0] val_wdata_c;

	// Lowest free node and whether any is free.
	logic [IW-1:0] free_idx;
	logic any_free;
	logic empty;
	logic hit;
	logic last_probe;
	logic fin_go;

	cle_node_mem #(
		.DEPTH(POOL_NODES),
		.IW(IW)
	) u_mem (
		.clk(clk),
		.rd_addr(rd_addr_c),
		.rd_val(rd_val),
		.rd_link(rd_link),
		.val_we(val_we_c),
		.val_addr(val_addr_c),
		.val_wdata(val_wdata_c),
		.link_we(link_we_c),
		.link_addr(link_addr_c),
		.link_wdata(link_wdata_c)
	);

	always_comb begin
		free_idx = '0;
		for (int i = POOL_NODES - 1; i >= 0; i--) begin
			if (free_q[i]) begin
				free_idx = IW'(i);
			end
		end
	end

	assign any_free = |free_q;
	assign empty = (count_q == '0);
	assign hit = (rd_val == key_q);
	assign last_probe = (CW'(k_q + 1'b1) == count_q);
	assign fin_go = !out_valid_q || out_ready;
	assign in_ready = (state_q == S_IDLE);

	assign out_valid = out_valid_q;
	assign status = out_status_q;
	assign removed_value = out_removed_q;
	assign list_length = out_length_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_c;
		end
	end

	// Next state and memory accesses.
	always_comb begin
		state_c = state_q;
		rd_addr_c = '0;
		val_we_c = 1'b0;
		val_addr_c = free_idx;
		val_wdata_c = (op_q == OP_INS_FRONT || op_q == OP_INS_BACK) ? key_q : ins_q;
		link_we_c = 1'b0;
		link_addr_c = '0;
		link_wdata_c = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_c = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				rd_addr_c = tail_q;
				priority case (op_q)
					OP_INS_FRONT, OP_INS_BACK: state_c = empty ? S_INS_A : S_INS_RD;
					OP_INS_AFTER: state_c = empty ? S_FIN : S_SRCH;
					OP_INS_BEFORE: state_c = empty ? S_FIN : S_PRE;
					OP_DEL_FRONT, OP_DEL_BACK: state_c = empty ? S_FIN : S_DEL_RD;
					default: state_c = S_FIN;
				endcase
			end
			S_INS_RD: state_c = S_INS_A;
			S_PRE: begin
				rd_addr_c = rd_link;
				state_c = S_SRCH;
			end
			S_SRCH: begin
				rd_addr_c = rd_link;
				if (hit) begin
					state_c = S_INS_A;
				end else if (last_probe) begin
					state_c = S_FIN;
				end
			end
			S_INS_A: begin
				if (!any_free) begin
					state_c = S_FIN;
				end else begin
					val_we_c = 1'b1;
					link_we_c = 1'b1;
					link_addr_c = free_idx;
					link_wdata_c = empty ? free_idx : nxt_q;
					state_c = S_INS_B;
				end
			end
			S_INS_B: begin
				link_we_c = 1'b1;
				link_addr_c = empty ? n_q : cur_q;
				link_wdata_c = n_q;
				state_c = S_FIN;
			end
			S_DEL_RD: begin
				rd_addr_c = rd_link;
				if (count_q == CW'(1)) begin
					state_c = S_FIN;
				end else if (op_q == OP_DEL_FRONT) begin
					state_c = S_DEL_F;
				end else begin
					state_c = S_DEL_B;
				end
			end
			S_DEL_F: begin
				link_we_c = 1'b1;
				link_addr_c = tail_q;
				link_wdata_c = rd_link;
				state_c = S_FIN;
			end
			S_DEL_B: begin
				rd_addr_c = rd_link;
				if (rd_link == tail_q) begin
					link_we_c = 1'b1;
					link_addr_c = rd_q;
					link_wdata_c = tnext_q;
					state_c = S_FIN;
				end
			end
			S_FIN: begin
				if (fin_go) begin
					state_c = S_IDLE;
				end
			end
			default: state_c = S_IDLE;
		endcase
	end

	// List state: free mask, tail and length.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q <= '1;
			tail_q <= '0;
			count_q <= '0;
		end else begin
			priority case (state_q)
				S_INS_B: begin
					free_q[n_q] <= 1'b0;
					count_q <= CW'(count_q + 1'b1);
					if (empty || op_q == OP_INS_BACK
					    || (op_q == OP_INS_AFTER && cur_q == tail_q)) begin
						tail_q <= n_q;
					end
				end
				S_DEL_RD: begin
					if (count_q == CW'(1)) begin
						free_q[tail_q] <= 1'b1;
						count_q <= '0;
						tail_q <= '0;
					end
				end
				S_DEL_F: begin
					free_q[rd_q] <= 1'b1;
					count_q <= CW'(count_q - 1'b1);
				end
				S_DEL_B: begin
					if (rd_link == tail_q) begin
						free_q[tail_q] <= 1'b1;
						count_q <= CW'(count_q - 1'b1);
						tail_q <= rd_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Operation registers and walk pointers.
	always_ff @(posedge clk) begin
		priority case (state_q)
			S_IDLE: begin
				op_q <= opcode;
				key_q <= data_value;
				ins_q <= insert_value;
				status_q <= ST_OK;
				removed_q <= '0;
			end
			S_DISPATCH: begin
				rd_q <= tail_q;
				cur_q <= tail_q;
				k_q <= '0;
				if (empty && op_q != OP_INS_FRONT && op_q != OP_INS_BACK
				    && (op_q == OP_INS_AFTER || op_q == OP_INS_BEFORE
				        || op_q == OP_DEL_FRONT || op_q == OP_DEL_BACK)) begin
					status_q <= ST_EMPTY;
				end
			end
			S_INS_RD: nxt_q <= rd_link;
			S_PRE: rd_q <= rd_link;
			S_SRCH: begin
				if (op_q == OP_INS_AFTER) begin
					// The node read is the candidate itself.
					if (hit) begin
						cur_q <= rd_q;
						nxt_q <= rd_link;
					end else begin
						rd_q <= rd_link;
					end
				end else begin
					// The node read follows cur_q; the new node goes between them.
					if (hit) begin
						nxt_q <= rd_q;
					end else begin
						cur_q <= rd_q;
						rd_q <= rd_link;
					end
				end
				k_q <= CW'(k_q + 1'b1);
				if (!hit && last_probe) begin
					status_q <= ST_NOT_FOUND;
				end
			end
			S_INS_A: begin
				n_q <= free_idx;
				if (!any_free) begin
					status_q <= ST_FULL;
				end
			end
			S_DEL_RD: begin
				rd_q <= rd_link;
				tnext_q <= rd_link;
				if (count_q == CW'(1) || op_q == OP_DEL_BACK) begin
					removed_q <= rd_val;
				end
			end
			S_DEL_F: removed_q <= rd_val;
			S_DEL_B: begin
				if (rd_link != tail_q) begin
					rd_q <= rd_link;
				end
			end
			default: begin
			end
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_FIN && fin_go) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FIN && fin_go) begin
			out_status_q <= status_q;
			out_removed_q <= removed_q;
			out_length_q <= count_q;
		end
	end

	`CLE_ASSERT(a_count_bound, (count_q <= CW'(POOL_NODES)), "list length beyond pool size")
	`CLE_ASSERT(a_free_matches_count, ($countones(~free_q) == int'(count_q)), "free mask and length disagree")
	`CLE_ASSERT(a_accept_dispatch, (in_valid && in_ready |=> state_q == S_DISPATCH), "accepted transfer not dispatched")
	`CLE_ASSERT_NEVER(a_fin_overwrite, (state_q == S_FIN && out_valid_q && !out_ready && state_c != S_FIN), "result dropped while receiver stalls")
endmodule
`default_nettype wire
